// File: src/dd_odo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dd_odo_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  // Fixed-point constants
  localparam logic [15:0] RADIUS_RST   = 16'd5898;
  localparam logic [23:0] INV_TRACK_RST = 24'd105703;
  localparam logic signed [31:0] RPM_TO_RAD = 32'sd1756906;    // 2*pi/60, Q0.24
  localparam logic signed [31:0] US_TO_SEC  = 32'sd1099512;    // 1e-6 s, Q0.40
  localparam logic signed [31:0] RAD_TO_BAM = 32'sd683565276;  // 2^32/(2*pi), scaled
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // Register indexes
  localparam logic REG_RADIUS    = 1'b0;
  localparam logic REG_INV_TRACK = 1'b1;

  // Arctangent of 2^-k as binary angle
  function automatic logic [29:0] atan_step(input logic [4:0] k);
    logic [29:0] r;
    case (k)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // Round half up, then arithmetic shift right
  function automatic logic signed [79:0] rshr(input logic signed [79:0] v,
                                              input logic [5:0] s);
    logic signed [79:0] h;
    h = 80'sd1 <<< (s - 6'd1);
    return (v + h) >>> s;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [79:0] v);
    logic signed [23:0] r;
    if (v > 80'sd8388607) r = 24'sh7FFFFF;
    else if (v < -80'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat_quat(input logic signed [79:0] v);
    logic signed [15:0] r;
    if (v > 80'sd16384) r = 16'sd16384;
    else if (v < -80'sd16384) r = -16'sd16384;
    else r = v[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/dd_odo_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// 48 x 32 signed multiply in two 24-bit partial products, done high with the product
module dd_odo_mul (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [47:0] a,
  input  wire logic signed [31:0] b,
  output logic                    done,
  output logic signed [79:0]      product
);
  logic signed [47:0] a_q;
  logic signed [31:0] b_q;
  logic signed [56:0] pp_lo;
  logic signed [55:0] pp_hi;
  logic [1:0]         vld;

  // Operand capture, partial products, then sum
  always_ff @(posedge clk) begin
    a_q     <= a;
    b_q     <= b;
    pp_lo   <= $signed({1'b0, a_q[23:0]}) * b_q;
    pp_hi   <= $signed(a_q[47:24]) * b_q;
    product <= (80'(pp_hi) <<< 24) + 80'(pp_lo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[0], start};
      done <= vld[1];
    end
  end
endmodule
`default_nettype wire

// File: src/dd_odo_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// Iterative rotation-mode CORDIC, one step per cycle, cos/sin in Q1.30
module dd_odo_cordic
  import dd_odo_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [31:0]        angle,
  output logic                    busy,
  output logic signed [31:0]      cos_out,
  output logic signed [31:0]      sin_out
);
  localparam int IW = $clog2(CORDIC_STEPS + 1);

  logic signed [33:0] x, y;
  logic signed [32:0] z;
  logic               flip;
  logic [IW-1:0]      i;
  logic [31:0]        folded;
  logic [4:0]         k;
  logic signed [32:0] da;

  // Fold second and third quadrant by half a turn
  assign folded = (angle[31:30] == 2'b01 || angle[31:30] == 2'b10) ?
                  angle + 32'h8000_0000 : angle;
  assign k  = 5'(i);
  assign da = $signed({3'b000, atan_step(k)});

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_GAIN;
      y    <= '0;
      z    <= $signed({folded[31], folded});
      flip <= (angle[31:30] == 2'b01 || angle[31:30] == 2'b10);
    end else if (busy) begin
      if (!z[32]) begin
        x <= x - (y >>> k);
        y <= y + (x >>> k);
        z <= z - da;
      end else begin
        x <= x + (y >>> k);
        y <= y - (x >>> k);
        z <= z + da;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      i    <= '0;
    end else if (start) begin
      busy <= 1'b1;
      i    <= '0;
    end else if (busy) begin
      i <= i + 1'b1;
      if (i == IW'(CORDIC_STEPS - 1)) busy <= 1'b0;
    end
  end

  assign cos_out = flip ? -x[31:0] : x[31:0];
  assign sin_out = flip ? -y[31:0] : y[31:0];
endmodule
`default_nettype wire

// File: src/diff_drive_odometry.sv
`timescale 1ns / 1ps
`default_nettype none
// Differential-drive odometry. Each input transfer carries four wheel speeds and the
// elapsed time; one output transfer returns the integrated pose (x, y, heading as a
// binary angle), the half-heading quaternion terms, forward speed and yaw rate.
// An item runs twelve multiplies on one shared 48x32 multiplier, then a CORDIC pass on
// the new half heading; the output register is loaded once that pass is done and the
// output register is free, then the sequencer goes back to idle. The first CORDIC pass
// overlaps the first six multiplies; beyond 24 steps it holds off the multiplier.
// s_tready is high only while no item is in work; a finished result waits in the
// output register while the next item is accepted.
module diff_drive_odometry
  import dd_odo_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // front_right_speed, front_left_speed, rear_right_speed, rear_left_speed,
  // elapsed_us, 4 bits zero fill
  input  wire logic [103:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // pos_x, pos_y, heading, quat_z, quat_w, forward_speed, yaw_rate
  output logic [175:0]      m_tdata,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [23:0]  cfg_data
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_QUAT  = 3'd3;

  localparam logic [3:0] OP_SUM_R   = 4'd0;
  localparam logic [3:0] OP_SPEED   = 4'd1;
  localparam logic [3:0] OP_DIFF_R  = 4'd2;
  localparam logic [3:0] OP_DIFF    = 4'd3;
  localparam logic [3:0] OP_YAW     = 4'd4;
  localparam logic [3:0] OP_TIME    = 4'd5;
  localparam logic [3:0] OP_VCOS    = 4'd6;
  localparam logic [3:0] OP_DX      = 4'd7;
  localparam logic [3:0] OP_VSIN    = 4'd8;
  localparam logic [3:0] OP_DY      = 4'd9;
  localparam logic [3:0] OP_WT      = 4'd10;
  localparam logic [3:0] OP_DH      = 4'd11;

  logic [2:0]  state;
  logic [3:0]  op;
  logic [15:0] radius;
  logic [23:0] inv_track;
  logic signed [31:0] x_accum, y_accum;
  logic [31:0] heading_accum;

  logic signed [21:0] s_left, s_right;
  logic [19:0]        dt_us;
  logic signed [47:0] p;
  logic signed [23:0] v, w;
  logic signed [31:0] d;
  logic signed [21:0] t;

  logic signed [47:0] mul_a;
  logic signed [31:0] mul_b;
  logic               mul_start, mul_done;
  logic signed [79:0] prod;

  logic               cor_start, cor_busy;
  logic [31:0]        cor_angle;
  logic signed [31:0] cor_cos, cor_sin;

  logic               accept, out_free;
  logic signed [79:0] r20, r30;
  logic signed [32:0] sum_xy;
  logic signed [31:0] sum_sat;
  logic [31:0]        heading_next;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign r20      = rshr(prod, 6'd20);
  assign r30      = rshr(prod, 6'd30);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      radius    <= RADIUS_RST;
      inv_track <= INV_TRACK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS:    radius    <= cfg_data[15:0];
        REG_INV_TRACK: inv_track <= cfg_data;
        default: ;
      endcase
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_SUM_R:  begin mul_a = 48'(s_left + s_right); mul_b = $signed({16'd0, radius}); end
      OP_SPEED:  begin mul_a = p; mul_b = RPM_TO_RAD; end
      OP_DIFF_R: begin mul_a = 48'(s_right - s_left); mul_b = $signed({16'd0, radius}); end
      OP_DIFF:   begin mul_a = p; mul_b = RPM_TO_RAD; end
      OP_YAW:    begin mul_a = 48'(d); mul_b = $signed({8'd0, inv_track}); end
      OP_TIME:   begin mul_a = $signed({28'd0, dt_us}); mul_b = US_TO_SEC; end
      OP_VCOS:   begin mul_a = 48'(v); mul_b = cor_cos; end
      OP_DX:     begin mul_a = p; mul_b = 32'(t); end
      OP_VSIN:   begin mul_a = 48'(v); mul_b = cor_sin; end
      OP_DY:     begin mul_a = p; mul_b = 32'(t); end
      OP_WT:     begin mul_a = 48'(w); mul_b = 32'(t); end
      OP_DH:     begin mul_a = p; mul_b = RAD_TO_BAM; end
      default: ;
    endcase
  end

  // Position update with saturation
  always_comb begin
    if (op == OP_DX) sum_xy = 33'(x_accum) + 33'($signed(r20[31:0]));
    else             sum_xy = 33'(y_accum) + 33'($signed(r20[31:0]));
    if (sum_xy > 33'sd2147483647)       sum_sat = 32'sh7FFF_FFFF;
    else if (sum_xy < -33'sd2147483648) sum_sat = 32'sh8000_0000;
    else                                sum_sat = sum_xy[31:0];
  end

  assign heading_next = heading_accum + 32'(rshr(prod, 6'd16));
  assign mul_start    = (state == ST_ISSUE) && !(op == OP_VCOS && cor_busy);
  assign cor_start    = accept || (state == ST_WAIT && mul_done && op == OP_DH);
  assign cor_angle    = accept ? heading_accum : {1'b0, heading_next[31:1]};

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      op            <= OP_SUM_R;
      x_accum       <= '0;
      y_accum       <= '0;
      heading_accum <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op    <= OP_SUM_R;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (mul_start) state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (mul_done) begin
            op    <= op + 4'd1;
            state <= (op == OP_DH) ? ST_QUAT : ST_ISSUE;
            case (op)
              OP_DX:  x_accum <= sum_sat;
              OP_DY:  y_accum <= sum_sat;
              OP_DH:  heading_accum <= heading_next;
              default: ;
            endcase
          end
        end
        ST_QUAT: begin
          if (!cor_busy && out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s_right <= 22'($signed(s_tdata[19:0])) + 22'($signed(s_tdata[59:40]));
      s_left  <= 22'($signed(s_tdata[39:20])) + 22'($signed(s_tdata[79:60]));
      dt_us   <= s_tdata[99:80];
    end
    if (state == ST_WAIT && mul_done) begin
      case (op)
        OP_SUM_R, OP_DIFF_R: p <= prod[47:0];
        OP_SPEED:            v <= sat24(r30);
        OP_DIFF:             d <= rshr(prod, 6'd29) >>> 0 == 0 ? 32'sd0 :
                                  32'(rshr(prod, 6'd29));
        OP_YAW:              w <= sat24(rshr(prod, 6'd16));
        OP_TIME:             t <= 22'(r20);
        OP_VCOS, OP_VSIN:    p <= r30[47:0];
        OP_WT:               p <= r20[47:0];
        default: ;
      endcase
    end
    if (state == ST_QUAT && !cor_busy && out_free) begin
      m_tdata <= {w, v,
                  sat_quat(rshr(80'(cor_cos), 6'd16)),
                  sat_quat(rshr(80'(cor_sin), 6'd16)),
                  heading_accum, y_accum, x_accum};
    end
  end

  dd_odo_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (prod)
  );

  dd_odo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .angle   (cor_angle),
    .busy    (cor_busy),
    .cos_out (cor_cos),
    .sin_out (cor_sin)
  );
endmodule
`default_nettype wire

// File: verif/tb_diff_drive_odometry.sv
`timescale 1ns / 1ps
module tb_diff_drive_odometry;
  import dd_odo_pkg::*;

  typedef struct packed {
    logic [3:0] fill;
    logic [19:0] elapsed_us;
    logic signed [19:0] rl, rr, fl, fr;
  } wheel_item_t;

  typedef struct packed {
    logic signed [23:0] yaw_rate;
    logic signed [23:0] forward_speed;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_z;
    logic [31:0] heading;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } pose_t;

  localparam int STEPS = 16;
  localparam int SETTLE = 200;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [103:0] s_tdata;
  logic [175:0] m_tdata;
  logic cfg_we, cfg_index;
  logic [23:0] cfg_data;

  diff_drive_odometry dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .cfg_we, .cfg_index, .cfg_data
  );

  // Predictor state
  longint radius_q, inv_track_q;
  longint px, py;
  logic [31:0] hdg;

  wheel_item_t pending_items[$];
  pose_t expected_poses[$];
  int fail_count;
  bit hold_off;
  int gap_left, burst_left;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shr(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint atan_bam(int k);
    longint tbl[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0};
    return tbl[k];
  endfunction

  // Fold to the right half plane, then rotate from the limit gain
  task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
    longint x, y, z, xs, ys;
    bit flip;
    x = 652032874; y = 0; flip = 0;
    if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
      ang = ang + 32'h8000_0000;
      flip = 1;
    end
    z = longint'(signed'(ang));
    for (int i = 0; i < STEPS; i++) begin
      xs = shr_floor(x, i % 32); ys = shr_floor(y, i % 32);
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_bam(i % 32);
      end else begin
        x += ys; y -= xs; z += atan_bam(i % 32);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_pose(input wheel_item_t it);
    longint sl, sr, v, d, w, t, c, s, dx, dy, dh;
    pose_t p;
    sl = longint'(it.fl) + longint'(it.rl);
    sr = longint'(it.fr) + longint'(it.rr);
    v = clip(round_shr((sl + sr) * radius_q * 1756906, 30), -8388608, 8388607);
    d = round_shr((sr - sl) * radius_q * 1756906, 29);
    w = clip(round_shr(d * inv_track_q, 16), -8388608, 8388607);
    t = (longint'(it.elapsed_us) * 1099512 + 524288) >>> 20;
    rotate(hdg, c, s);
    dx = round_shr(round_shr(v * c, 30) * t, 20);
    dy = round_shr(round_shr(v * s, 30) * t, 20);
    px = clip(px + dx, -64'sd2147483648, 64'sd2147483647);
    py = clip(py + dy, -64'sd2147483648, 64'sd2147483647);
    dh = round_shr(round_shr(w * t, 20) * 683565276, 16);
    hdg = hdg + dh[31:0];
    rotate({1'b0, hdg[31:1]}, c, s);
    p.pos_x = px[31:0];
    p.pos_y = py[31:0];
    p.heading = hdg;
    p.quat_w = 16'(clip(round_shr(c, 16), -16384, 16384));
    p.quat_z = 16'(clip(round_shr(s, 16), -16384, 16384));
    p.forward_speed = v[23:0];
    p.yaw_rate = w[23:0];
    expected_poses.push_back(p);
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: bursts and gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
      gap_left <= 0;
      burst_left <= 0;
    end else if (s_tvalid && !s_tready) begin
      // hold the offered item
    end else begin
      if (s_tvalid) begin
        predict_pose(pending_items.pop_front());
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 0;
      end else if (pending_items.size() > 0) begin
        s_tdata <= pending_items[0];
        s_tvalid <= 1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 8);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 150);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // Receiver stall pattern
  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else if (hold_off) m_tready <= 0;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  // Monitor
  always @(posedge clk) begin
    pose_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_poses.size() == 0) begin
        $error("unexpected result transfer");
        fail_count++;
      end else begin
        want = expected_poses.pop_front();
        if (got.pos_x !== want.pos_x) begin
          $error("pos_x exp %0d got %0d", want.pos_x, got.pos_x); fail_count++;
        end
        if (got.pos_y !== want.pos_y) begin
          $error("pos_y exp %0d got %0d", want.pos_y, got.pos_y); fail_count++;
        end
        if (got.heading !== want.heading) begin
          $error("heading exp %0h got %0h", want.heading, got.heading); fail_count++;
        end
        if (got.quat_z !== want.quat_z) begin
          $error("quat_z exp %0d got %0d", want.quat_z, got.quat_z); fail_count++;
        end
        if (got.quat_w !== want.quat_w) begin
          $error("quat_w exp %0d got %0d", want.quat_w, got.quat_w); fail_count++;
        end
        if (got.forward_speed !== want.forward_speed) begin
          $error("forward_speed exp %0d got %0d", want.forward_speed, got.forward_speed);
          fail_count++;
        end
        if (got.yaw_rate !== want.yaw_rate) begin
          $error("yaw_rate exp %0d got %0d", want.yaw_rate, got.yaw_rate); fail_count++;
        end
      end
    end
  end

  function automatic wheel_item_t make_item(int fr, int fl, int rr, int rl, int dt);
    wheel_item_t it;
    it.fill = '0;
    it.fr = fr[19:0]; it.fl = fl[19:0]; it.rr = rr[19:0]; it.rl = rl[19:0];
    it.elapsed_us = dt[19:0];
    return it;
  endfunction

  function automatic int rand_speed();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? 524287 : -524288;
      1: return int'($urandom_range(0, 1048575)) - 524288;
      default: return int'($urandom_range(0, 4000)) - 2000;
    endcase
  endfunction

  function automatic int rand_dt();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 1048575;
      2: return $urandom_range(0, 1048575);
      default: return $urandom_range(50000, 200000);
    endcase
  endfunction

  task automatic write_reg(input logic idx, input logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    if (idx == REG_RADIUS) radius_q = val[15:0];
    else inv_track_q = val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !s_tvalid && expected_poses.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    int base, spread;
    base = rand_speed();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        pending_items.push_back(make_item(rand_speed(), rand_speed(), rand_speed(),
                                          rand_speed(), rand_dt()));
      end else begin
        // plausible motion: sides near a common speed
        spread = int'($urandom_range(0, 400)) - 200;
        pending_items.push_back(make_item(int'(clip(base + spread, -524288, 524287)),
          int'(clip(base - spread, -524288, 524287)),
          int'(clip(base + spread, -524288, 524287)),
          int'(clip(base - spread, -524288, 524287)), rand_dt()));
      end
    end
  endtask

  initial begin
    logic [15:0] radii[4] = '{16'd5898, 16'd1, 16'hFFFF, 16'd20000};
    logic [23:0] tracks[4] = '{24'd105703, 24'hFFFFFF, 24'd1, 24'd300000};
    rst = 1; cfg_we = 0; cfg_index = 0; cfg_data = 0; s_tdata = '0; hold_off = 0;
    fail_count = 0;
    radius_q = 5898; inv_track_q = 105703; px = 0; py = 0; hdg = 0;
    repeat (5) @(posedge clk);
    rst <= 0;

    // Directed: extremes, zero time, turning in place, heading wrap
    write_reg(REG_RADIUS, 24'd5898);
    write_reg(REG_INV_TRACK, 24'd105703);
    pending_items.push_back(make_item(0, 0, 0, 0, 0));
    pending_items.push_back(make_item(524287, 524287, 524287, 524287, 1048575));
    pending_items.push_back(make_item(-524288, -524288, -524288, -524288, 1048575));
    pending_items.push_back(make_item(524287, -524288, 524287, -524288, 1048575));
    pending_items.push_back(make_item(-524288, 524287, -524288, 524287, 1048575));
    pending_items.push_back(make_item(1000, 1000, 1000, 1000, 0));
    for (int i = 0; i < 8; i++)
      pending_items.push_back(make_item(524287, -524288, 524287, -524288, 1048575));
    pending_items.push_back(make_item(3000, 2000, 3000, 2000, 100000));
    pending_items.push_back(make_item(-3000, -2000, -3000, -2000, 100000));
    drain();

    // Zero registers
    write_reg(REG_RADIUS, 24'd0);
    write_reg(REG_INV_TRACK, 24'd0);
    pending_items.push_back(make_item(5000, -5000, 5000, -5000, 100000));
    pending_items.push_back(make_item(524287, 1, 524287, 1, 1048575));
    drain();

    // Random phases over several settings
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_RADIUS, {8'd0, radii[ph]});
      write_reg(REG_INV_TRACK, tracks[ph]);
      random_phase(110);
      if (ph == 1) begin
        // long receiver hold-off while the sender keeps offering
        @(posedge clk);
        hold_off = 1;
        repeat (2000) @(posedge clk);
        hold_off = 0;
      end
      drain();
    end

    if (fail_count == 0 && expected_poses.size() == 0) begin
      $display("tb_diff_drive_odometry: PASS");
    end else begin
      $display("tb_diff_drive_odometry: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_diff_drive_odometry: FAIL");
    $finish;
  end

endmodule

// File: diff_drive_odometry.f
src/dd_odo_pkg.sv
src/dd_odo_mul.sv
src/dd_odo_cordic.sv
src/diff_drive_odometry.sv
verif/tb_diff_drive_odometry.sv
